// ===== hdl/clnw_pkg.sv =====
// Package for the character LCD number writer: codes, microcode table and helpers.
`timescale 1ns / 1ps
package clnw_pkg;

  localparam int MAX_DIGITS_DEF = 16;
  localparam int VALUE_BITS_DEF = 16;
  localparam int FUNC_W         = 3;
  localparam int LINE_W         = 2;
  localparam int COLUMN_W       = 6;
  localparam int COUNT_IN_W     = 5;

  localparam logic [FUNC_W-1:0] FUNC_CHAR = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_UDEC = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SDEC = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_HEX  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_BIN  = 3'd4;

  localparam logic [LINE_W-1:0] LINE_FIRST = 2'd1;

  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [6:0] LINE2_OFFSET  = 7'h40;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_WAIT, OP_CONV, OP_CMD, OP_SIGN, OP_DIGIT, OP_CHAR, OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER, COND_ALWAYS, COND_CONV_MORE, COND_IS_CHAR, COND_NO_DIGITS, COND_MORE_DIGITS
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  localparam pc_t PC_WAIT  = 3'd0;
  localparam pc_t PC_CONV  = 3'd1;
  localparam pc_t PC_CMD   = 3'd2;
  localparam pc_t PC_SIGN  = 3'd3;
  localparam pc_t PC_DIGIT = 3'd4;
  localparam pc_t PC_DONE  = 3'd5;
  localparam pc_t PC_CHAR  = 3'd6;

  function automatic ctrl_t prog_rom(pc_t pc);
    ctrl_t w;
    unique case (pc)
      PC_WAIT:  w = '{OP_WAIT,  COND_NEVER,       PC_WAIT};
      PC_CONV:  w = '{OP_CONV,  COND_CONV_MORE,   PC_CONV};
      PC_CMD:   w = '{OP_CMD,   COND_IS_CHAR,     PC_CHAR};
      PC_SIGN:  w = '{OP_SIGN,  COND_NO_DIGITS,   PC_WAIT};
      PC_DIGIT: w = '{OP_DIGIT, COND_MORE_DIGITS, PC_DIGIT};
      PC_DONE:  w = '{OP_NOP,   COND_ALWAYS,      PC_WAIT};
      PC_CHAR:  w = '{OP_CHAR,  COND_ALWAYS,      PC_WAIT};
      default:  w = '{OP_NOP,   COND_ALWAYS,      PC_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = CH_A + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== hdl/char_lcd_number_writer_top.sv =====
// Character LCD number writer: microcoded sequencer emitting LCD bus writes per request.
// After acceptance, decimal modes first run one double-dabble step per value bit; every mode
// then offers the set-address command, followed by the character in char mode or else by the sign
// (signed decimal only) and the digits. Output stalls hold the sequencer. One request at a time.
// Reset (async, active low) returns the step counter to the wait step and empties the output.
`timescale 1ns / 1ps
module char_lcd_number_writer_top #(
  parameter int MaxDigits = clnw_pkg::MAX_DIGITS_DEF,
  parameter int ValueBits = clnw_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [clnw_pkg::FUNC_W-1:0]       func_i,
  input  logic [clnw_pkg::LINE_W-1:0]       line_i,
  input  logic [clnw_pkg::COLUMN_W-1:0]     column_i,
  input  logic [ValueBits-1:0]              value_i,
  input  logic [clnw_pkg::COUNT_IN_W-1:0]   digit_count_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              is_data_o,
  output logic [7:0]                        bus_byte_o,
  output logic                              last_o
);
  import clnw_pkg::*;

  localparam int ND   = (ValueBits * 3) / 10 + 1;
  localparam int CW   = $clog2(MaxDigits + 1);
  localparam int DIW  = $clog2(ND);
  localparam int VIW  = $clog2(ValueBits);
  localparam int PW0  = (CW > $clog2(ND + 1)) ? CW : $clog2(ND + 1);
  localparam int PW   = (PW0 > $clog2(ValueBits + 1)) ? PW0 : $clog2(ValueBits + 1);

  pc_t                     pc_q, pc_d;
  logic [FUNC_W-1:0]       func_q;
  logic [6:0]              addr_q;
  logic [ValueBits-1:0]    num_q;
  logic [ValueBits-1:0]    sh_q;
  logic                    neg_q;
  logic [CW-1:0]           count_q, count_d;
  logic [VIW-1:0]          bit_cnt_q;
  logic [ND-1:0][3:0]      bcd_q, bcd_adj;
  logic [4*ND-1:0]         bcd_flat;

  logic                    out_valid_q, out_valid_d;
  logic                    is_data_q, is_data_d;
  logic [7:0]              bus_byte_q, bus_byte_d;
  logic                    last_q, last_d;

  ctrl_t                   ctrl;
  logic                    accept;
  logic                    out_full;
  logic                    is_emit;
  logic                    emit_go;
  logic                    cond_true;
  logic                    is_dec;
  logic                    in_neg;
  logic [ValueBits-1:0]    in_mag;
  logic [CW-1:0]           in_count;
  logic [6:0]              in_addr;
  logic [PW-1:0]           pos;
  logic [3:0]              digit;

  assign ctrl     = prog_rom(pc_q);
  assign in_ready_o = (ctrl.op == OP_WAIT);
  assign accept   = in_valid_i && in_ready_o;
  assign out_full = out_valid_q && !out_ready_i;
  assign is_dec   = (func_q == FUNC_UDEC) || (func_q == FUNC_SDEC);

  assign in_neg   = (func_i == FUNC_SDEC) && value_i[ValueBits-1];
  assign in_mag   = in_neg ? (~value_i + {{(ValueBits-1){1'b0}}, 1'b1}) : value_i;
  assign in_count = (int'(digit_count_i) > MaxDigits) ? CW'(MaxDigits) : CW'(digit_count_i);
  assign in_addr  = {1'b0, column_i} - 7'd1 + ((line_i == LINE_FIRST) ? 7'd0 : LINE2_OFFSET);

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
    end
    bcd_flat = {bcd_adj[ND-1:0]};
  end

  assign pos = PW'(count_q) - PW'(1);

  always_comb begin
    unique case (func_q)
      FUNC_HEX: begin
        if (pos < PW'(2)) begin
          digit = pos[0] ? num_q[7:4] : num_q[3:0];
        end else begin
          digit = 4'd0;
        end
      end
      FUNC_BIN: begin
        digit = (pos < PW'(ValueBits)) ? {3'b0, num_q[pos[VIW-1:0]]} : 4'd0;
      end
      default: begin
        digit = (pos < PW'(ND)) ? bcd_q[pos[DIW-1:0]] : 4'd0;
      end
    endcase
  end

  always_comb begin
    unique case (ctrl.cond)
      COND_ALWAYS:      cond_true = 1'b1;
      COND_CONV_MORE:   cond_true = is_dec && (bit_cnt_q != VIW'(ValueBits - 1));
      COND_IS_CHAR:     cond_true = (func_q == FUNC_CHAR);
      COND_NO_DIGITS:   cond_true = (count_q == '0);
      COND_MORE_DIGITS: cond_true = (count_q != CW'(1));
      default:          cond_true = 1'b0;
    endcase
  end

  always_comb begin
    is_emit = (ctrl.op == OP_CMD) || (ctrl.op == OP_DIGIT) || (ctrl.op == OP_CHAR) ||
              ((ctrl.op == OP_SIGN) && (func_q == FUNC_SDEC));
    emit_go = is_emit && !out_full;

    out_valid_d = out_valid_q && !out_ready_i;
    is_data_d   = is_data_q;
    bus_byte_d  = bus_byte_q;
    last_d      = last_q;
    count_d     = count_q;

    if (emit_go) begin
      out_valid_d = 1'b1;
      is_data_d   = 1'b1;
      unique case (ctrl.op)
        OP_CMD: begin
          is_data_d  = 1'b0;
          bus_byte_d = CMD_SET_DDRAM | {1'b0, addr_q};
          last_d     = (func_q != FUNC_CHAR) && (func_q != FUNC_SDEC) && (count_q == '0);
        end
        OP_SIGN: begin
          bus_byte_d = neg_q ? CH_MINUS : CH_PLUS;
          last_d     = (count_q == '0);
        end
        OP_DIGIT: begin
          bus_byte_d = digit_char(digit);
          last_d     = (count_q == CW'(1));
          count_d    = count_q - CW'(1);
        end
        default: begin
          bus_byte_d = num_q[7:0];
          last_d     = 1'b1;
        end
      endcase
    end

    if (accept) begin
      count_d = in_count;
    end

    if (ctrl.op == OP_WAIT) begin
      pc_d = (accept && (func_i <= FUNC_BIN)) ? PC_CONV : PC_WAIT;
    end else if (is_emit && out_full) begin
      pc_d = pc_q;
    end else if (cond_true) begin
      pc_d = ctrl.target;
    end else begin
      pc_d = pc_q + pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_data_q  <= is_data_d;
    bus_byte_q <= bus_byte_d;
    last_q     <= last_d;
    count_q    <= count_d;
    if (accept) begin
      func_q    <= func_i;
      addr_q    <= in_addr;
      num_q     <= value_i;
      sh_q      <= in_mag;
      neg_q     <= in_neg;
      bit_cnt_q <= '0;
      bcd_q     <= '0;
    end else if (ctrl.op == OP_CONV && is_dec) begin
      bcd_q     <= {bcd_flat[4*ND-2:0], sh_q[ValueBits-1]};
      sh_q      <= {sh_q[ValueBits-2:0], 1'b0};
      bit_cnt_q <= bit_cnt_q + VIW'(1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_data_o   = is_data_q;
  assign bus_byte_o  = bus_byte_q;
  assign last_o      = last_q;

endmodule

// ===== dv/char_lcd_number_writer_top_tb.sv =====
// Self-checking testbench for the LCD number writer: predicts the bus writes of each request.
`timescale 1ns / 1ps
module char_lcd_number_writer_top_tb;
  import clnw_pkg::*;

  localparam int VALUE_W       = VALUE_BITS_DEF;
  localparam int DIGITS_MAX    = MAX_DIGITS_DEF;
  localparam int WATCHDOG_MAX  = 3000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 64;
  localparam logic [LINE_W-1:0] LINE_SECOND = 2'd2;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } lcd_write_t;

  class lcd_write_scoreboard;
    lcd_write_t pending_writes[$];
    int errors;
    int requests;
    int ignored;
    int writes_seen;

    function void note_request(logic [FUNC_W-1:0] func, logic [LINE_W-1:0] line,
                               logic [COLUMN_W-1:0] column, logic [VALUE_W-1:0] value,
                               logic [COUNT_IN_W-1:0] count);
      lcd_write_t writes[$];
      int         digs[DIGITS_MAX];
      int         n;
      int         base;
      logic [VALUE_W:0] mag;
      logic [6:0] addr;
      logic [7:0] ch;
      if (func > FUNC_BIN) begin
        ignored++;
        return;
      end
      requests++;
      n = (count > DIGITS_MAX) ? DIGITS_MAX : int'(count);
      addr = {1'b0, column} - 7'd1 + ((line == LINE_FIRST) ? 7'd0 : LINE2_OFFSET);
      writes.push_back('{1'b0, CMD_SET_DDRAM | {1'b0, addr}, 1'b0});
      mag = {1'b0, value};
      base = 10;
      case (func)
        FUNC_SDEC: begin
          if (value[VALUE_W-1]) begin
            mag = {1'b1, {VALUE_W{1'b0}}} - {1'b0, value};
          end
          writes.push_back('{1'b1, value[VALUE_W-1] ? CH_MINUS : CH_PLUS, 1'b0});
        end
        FUNC_HEX: begin
          base = 16;
          mag = {1'b0, 8'h00, value[7:0]};
        end
        FUNC_BIN: begin
          base = 2;
        end
        default: ;
      endcase
      if (func == FUNC_CHAR) begin
        writes.push_back('{1'b1, value[7:0], 1'b0});
      end else begin
        for (int i = 0; i < n; i++) begin
          digs[i] = int'(mag % base);
          mag = (VALUE_W+1)'(mag / base);
        end
        for (int i = n - 1; i >= 0; i--) begin
          ch = (digs[i] < 10) ? CH_ZERO + 8'(digs[i]) : CH_A + 8'(digs[i] - 10);
          writes.push_back('{1'b1, ch, 1'b0});
        end
      end
      writes[writes.size()-1].last = 1'b1;
      foreach (writes[i]) pending_writes.push_back(writes[i]);
    endfunction

    function void check_write(logic is_data, logic [7:0] bus_byte, logic last);
      lcd_write_t exp_w;
      writes_seen++;
      if (pending_writes.size() == 0) begin
        $error("unexpected LCD write: is_data %0d bus_byte 0x%02h last %0d",
               is_data, bus_byte, last);
        errors++;
        return;
      end
      exp_w = pending_writes.pop_front();
      if (is_data !== exp_w.is_data) begin
        $error("is_data mismatch: expected %0d, actual %0d", exp_w.is_data, is_data);
        errors++;
      end
      if (bus_byte !== exp_w.bus_byte) begin
        $error("bus_byte mismatch: expected 0x%02h, actual 0x%02h", exp_w.bus_byte, bus_byte);
        errors++;
      end
      if (last !== exp_w.last) begin
        $error("last mismatch: expected %0d, actual %0d", exp_w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [FUNC_W-1:0]     func_i = FUNC_CHAR;
  logic [LINE_W-1:0]     line_i = LINE_FIRST;
  logic [COLUMN_W-1:0]   column_i = '0;
  logic [VALUE_W-1:0]    value_i = '0;
  logic [COUNT_IN_W-1:0] digit_count_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  is_data_o;
  logic [7:0]            bus_byte_o;
  logic                  last_o;

  lcd_write_scoreboard sb = new();
  int send_idle_pct = 29;
  int recv_idle_pct = 65;
  bit hold_receiver = 1'b0;
  int quiet_cycles = 0;

  char_lcd_number_writer_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .line_i       (line_i),
    .column_i     (column_i),
    .value_i      (value_i),
    .digit_count_i(digit_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_data_o    (is_data_o),
    .bus_byte_o   (bus_byte_o),
    .last_o       (last_o)
  );

  always #10 clk_i = ~clk_i;

  task automatic send_request(logic [FUNC_W-1:0] func, logic [LINE_W-1:0] line,
                              logic [COLUMN_W-1:0] column, logic [VALUE_W-1:0] value,
                              logic [COUNT_IN_W-1:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= func;
    line_i        <= line;
    column_i      <= column;
    value_i       <= value;
    digit_count_i <= count;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(func, line, column, value, count);
  endtask

  task automatic send_random();
    logic [FUNC_W-1:0]     func;
    logic [LINE_W-1:0]     line;
    logic [COLUMN_W-1:0]   column;
    logic [VALUE_W-1:0]    value;
    logic [COUNT_IN_W-1:0] count;
    func = ($urandom_range(99) < 6) ? FUNC_BIN + 3'($urandom_range(3, 1))
                                    : 3'($urandom_range(FUNC_BIN, FUNC_CHAR));
    if ($urandom_range(99) < 10) line = 2'($urandom_range(3, 0));
    else line = $urandom_range(1) ? LINE_FIRST : LINE_SECOND;
    column = ($urandom_range(99) < 10) ? 6'($urandom_range(63, 0)) : 6'($urandom_range(40, 1));
    case ($urandom_range(9))
      0: value = {1'b1, {(VALUE_W-1){1'b0}}};
      1: value = '1;
      2: value = 16'($urandom_range(9, 0));
      default: value = 16'($urandom);
    endcase
    count = ($urandom_range(99) < 15) ? 5'($urandom_range(31, 0)) : 5'($urandom_range(8, 1));
    send_request(func, line, column, value, count);
  endtask

  task automatic drain_writes();
    in_valid_i <= 1'b0;
    while (sb.pending_writes.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    @(posedge clk_i);
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_write(is_data_o, bus_byte_o, last_o);
      end
      if (hold_receiver) begin
        hold_receiver = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no request or write moved for %0d cycles", WATCHDOG_MAX);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int target;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(FUNC_CHAR, LINE_FIRST, 6'd1, 16'h0041, 5'd1);
    send_request(FUNC_CHAR, LINE_SECOND, 6'd40, 16'hFFFF, 5'd0);
    send_request(FUNC_UDEC, LINE_FIRST, 6'd1, 16'hFFFF, 5'd5);
    send_request(FUNC_UDEC, LINE_SECOND, 6'd16, 16'h0000, 5'd16);
    send_request(FUNC_UDEC, LINE_FIRST, 6'd8, 16'd12345, 5'd3);
    send_request(FUNC_UDEC, 2'd0, 6'd2, 16'hFFFF, 5'd31);
    send_request(FUNC_UDEC, LINE_FIRST, 6'd3, 16'd7, 5'd0);
    send_request(FUNC_SDEC, LINE_FIRST, 6'd1, 16'h8000, 5'd5);
    send_request(FUNC_SDEC, LINE_SECOND, 6'd5, 16'h7FFF, 5'd5);
    send_request(FUNC_SDEC, 2'd3, 6'd10, 16'hFFFF, 5'd1);
    send_request(FUNC_SDEC, LINE_FIRST, 6'd20, 16'h0000, 5'd0);
    send_request(FUNC_SDEC, LINE_SECOND, 6'd1, 16'h8000, 5'd31);
    send_request(FUNC_HEX, LINE_FIRST, 6'd1, 16'hABCD, 5'd2);
    send_request(FUNC_HEX, LINE_SECOND, 6'd33, 16'h12FE, 5'd31);
    send_request(FUNC_HEX, LINE_FIRST, 6'd4, 16'h00FF, 5'd0);
    send_request(FUNC_BIN, LINE_FIRST, 6'd1, 16'h5555, 5'd16);
    send_request(FUNC_BIN, LINE_SECOND, 6'd25, 16'hAAAA, 5'd31);
    send_request(FUNC_BIN, LINE_FIRST, 6'd9, 16'h0003, 5'd1);
    send_request(FUNC_CHAR, LINE_FIRST, 6'd0, 16'h0030, 5'd1);
    send_request(FUNC_UDEC, LINE_SECOND, 6'd0, 16'd42, 5'd2);
    send_request(FUNC_BIN, 2'd3, 6'd63, 16'hFFFF, 5'd4);
    for (int k = 1; k <= 3; k++) begin
      send_request(FUNC_BIN + 3'(k), LINE_FIRST, 6'd1, 16'h1234, 5'd4);
    end

    target = sb.requests + 34;
    while (sb.requests < target) begin
      if (sb.requests == target - 24) hold_receiver = 1'b1;
      send_random();
    end
    drain_writes();

    send_idle_pct = 65;
    recv_idle_pct = 29;
    target = sb.requests + 33;
    while (sb.requests < target) begin
      if (sb.requests == target - 16) drain_writes();
      send_random();
    end
    drain_writes();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    target = sb.requests + 33;
    while (sb.requests < target) send_random();
    drain_writes();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests in all five modes plus %0d with unused codes,",
             sb.requests, sb.ignored);
    $display("checking %0d LCD bus writes under three stall profiles.", sb.writes_seen);
    if (sb.errors == 0 && sb.pending_writes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
